### rtl/core/stereo_peak_meter_with_clip_hold_assert.svh
// ----------------------------------------------------------------------------
// Peak meter assertion macros
// Shared property forms for the meter's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef STEREO_PEAK_METER_WITH_CLIP_HOLD_ASSERT_SVH
`define STEREO_PEAK_METER_WITH_CLIP_HOLD_ASSERT_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define SPM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("peak meter check failed");

// Next-cycle implication, clocked on clk and disabled during reset.
`define SPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("peak meter check failed");

`endif

### rtl/core/spm_pkg.sv
// ----------------------------------------------------------------------------
// Peak meter package
// Field widths, register map, command codes and the segment threshold math.
// ----------------------------------------------------------------------------
package spm_pkg;

    localparam int LEVEL_W = 16;
    localparam int LIT_W   = 5;
    localparam int CNT_W   = 8;
    localparam int THR_W   = LEVEL_W + 1;

    localparam int SEGMENTS_DEFAULT = 16;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 48;

    localparam logic [LEVEL_W-1:0] DECAY_RESET      = 16'd55706;
    localparam logic [LEVEL_W-1:0] CLIP_LEVEL_RESET = 16'd16368;
    localparam logic [CNT_W-1:0]   CLIP_HOLD_RESET  = 8'd30;

    // word index of each register (byte address 4*i)
    localparam logic [1:0] REG_DECAY      = 2'd0;
    localparam logic [1:0] REG_CLIP_LEVEL = 2'd1;
    localparam logic [1:0] REG_CLIP_HOLD  = 2'd2;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_CLEAR = 1'b1
    } cmd_t;

    localparam longint DB_PER_OCTAVE_Q16 = 64'sd394566;

    // log2 in Q5.16 by repeated squaring; used at elaboration only
    function automatic logic [20:0] spm_log2_q16(input logic [LEVEL_W-1:0] x);
        logic [4:0]  n;
        logic [15:0] frac;
        logic [63:0] m;
        n    = 5'd0;
        frac = 16'd0;
        for (int b = 1; b < LEVEL_W; b++)
        begin
            if (x[b])
            begin
                n = 5'(b);
            end
        end
        m = 64'(x) << (30 - int'(n));
        for (int k = 1; k <= 16; k++)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30))
            begin
                m = m >> 1;
                frac[16-k] = 1'b1;
            end
        end
        return {n, frac};
    endfunction

    function automatic logic spm_seg_on(input logic [LEVEL_W-1:0] x, input int segs,
                                        input int idx);
        longint d;
        longint rhs;
        d   = DB_PER_OCTAVE_Q16 * (longint'(spm_log2_q16(x)) - longint'(14 * 65536));
        rhs = longint'(42 * idx - 36 * segs) <<< 32;
        return (x != '0) && (d * longint'(segs) > rhs);
    endfunction

    // smallest level that lights segment idx; 2^16 when none does
    function automatic logic [THR_W-1:0] spm_threshold(input int segs, input int idx);
        int lo;
        int hi;
        int mid;
        if (!spm_seg_on(16'hFFFF, segs, idx))
        begin
            return THR_W'(1 << LEVEL_W);
        end
        lo = 1;
        hi = (1 << LEVEL_W) - 1;
        for (int it = 0; it < THR_W; it++)
        begin
            if (lo < hi)
            begin
                mid = (lo + hi) >> 1;
                if (spm_seg_on(LEVEL_W'(mid), segs, idx))
                begin
                    hi = mid;
                end
                else
                begin
                    lo = mid + 1;
                end
            end
        end
        return THR_W'(lo);
    endfunction

endpackage

### rtl/core/stereo_peak_meter_with_clip_hold.sv
// ----------------------------------------------------------------------------
// Stereo peak meter with clip hold
// Usage:
//   s_* carries one word per display tick: tuser is the command (tick or
//   clear clip), tdata the left and right peaks in unsigned Q2.14. m_* returns
//   one word per input word: held levels, lit segment counts and clip flags.
//   The APB port sets decay factor, clip level and clip hold count; write it
//   only while no words are in flight.
// Timing:
//   From the accepting edge to m_tvalid a word passes three register stages:
//   input register, level update (one 16x16 multiply in the hold feedback
//   loop), then clip counter and segment compare into the output register.
//   One word per cycle is sustained with no gaps while m_tready stays high.
// Reset:
//   Held levels, clip counter and clip latch clear; registers return to
//   0.85 decay, clip level 16368, hold 30. No clearing pass is needed.
// Stall:
//   While m_tvalid is high and m_tready low the whole pipe holds and s_tready
//   drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module stereo_peak_meter_with_clip_hold #(
    parameter int SEGMENTS = spm_pkg::SEGMENTS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] left_peak, [31:16] right_peak
    input  logic [spm_pkg::S_DATA_W-1:0]   s_tdata,
    // [0] cmd
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] left_level, [31:16] right_level, [36:32] left_lit,
    // [41:37] right_lit, [42] clip_on, [43] clip_seen, [47:44] zero
    output logic [spm_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [spm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [spm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [spm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import spm_pkg::*;

    `include "stereo_peak_meter_with_clip_hold_assert.svh"

    // configuration registers
    logic [LEVEL_W-1:0] decay_reg;
    logic [LEVEL_W-1:0] clip_level_reg;
    logic [CNT_W-1:0]   clip_hold_reg;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg      <= DECAY_RESET;
            clip_level_reg <= CLIP_LEVEL_RESET;
            clip_hold_reg  <= CLIP_HOLD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_DECAY:      decay_reg      <= pwdata[LEVEL_W-1:0];
                REG_CLIP_LEVEL: clip_level_reg <= pwdata[LEVEL_W-1:0];
                REG_CLIP_HOLD:  clip_hold_reg  <= pwdata[CNT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_DECAY:      prdata = CFG_DATA_W'(decay_reg);
            REG_CLIP_LEVEL: prdata = CFG_DATA_W'(clip_level_reg);
            REG_CLIP_HOLD:  prdata = CFG_DATA_W'(clip_hold_reg);
            default:        prdata = '0;
        endcase
    end

    // pipeline control: every stage advances when the output can move
    logic advance;
    logic in_valid_reg;
    logic s1_valid_reg;
    logic out_valid_reg;
    cmd_t in_cmd_reg;
    cmd_t s1_cmd_reg;
    logic [LEVEL_W-1:0] in_left_reg;
    logic [LEVEL_W-1:0] in_right_reg;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg  <= s_tvalid;
            s1_valid_reg  <= in_valid_reg;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_cmd_reg   <= cmd_t'(s_tuser);
            in_left_reg  <= s_tdata[LEVEL_W-1:0];
            in_right_reg <= s_tdata[2*LEVEL_W-1:LEVEL_W];
            s1_cmd_reg   <= in_cmd_reg;
        end
    end

    // level update stage
    logic               level_update;
    logic [LEVEL_W-1:0] left_level;
    logic [LEVEL_W-1:0] right_level;
    logic [LIT_W-1:0]   left_lit;
    logic [LIT_W-1:0]   right_lit;

    assign level_update = advance && in_valid_reg && (in_cmd_reg == CMD_TICK);

    spm_channel #(
        .SEGMENTS (SEGMENTS)
    ) u_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (level_update),
        .peak   (in_left_reg),
        .decay  (decay_reg),
        .level  (left_level),
        .lit    (left_lit)
    );

    spm_channel #(
        .SEGMENTS (SEGMENTS)
    ) u_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (level_update),
        .peak   (in_right_reg),
        .decay  (decay_reg),
        .level  (right_level),
        .lit    (right_lit)
    );

    // clip stage
    logic               clip_step;
    logic               clip_hit;
    logic [LEVEL_W-1:0] louder;
    logic [CNT_W-1:0]   clip_cnt_reg;
    logic [CNT_W-1:0]   clip_cnt_next;
    logic [CNT_W-1:0]   clip_cnt_load;
    logic               clip_latch_reg;
    logic               clip_latch_next;

    assign clip_step = advance && s1_valid_reg;
    assign louder    = (left_level > right_level) ? left_level : right_level;
    assign clip_hit  = (louder >= clip_level_reg);

    always_comb
    begin
        clip_cnt_next   = clip_cnt_reg;
        clip_latch_next = clip_latch_reg;
        clip_cnt_load   = clip_hit ? clip_hold_reg : clip_cnt_reg;
        if (clip_step)
        begin
            case (s1_cmd_reg)
                CMD_CLEAR:
                begin
                    clip_cnt_next   = '0;
                    clip_latch_next = 1'b0;
                end
                default:
                begin
                    clip_latch_next = clip_latch_reg || clip_hit;
                    // count down after any reload
                    clip_cnt_next   = (clip_cnt_load != '0) ? clip_cnt_load - 1'b1 : '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_cnt_reg   <= '0;
            clip_latch_reg <= 1'b0;
        end
        else
        begin
            clip_cnt_reg   <= clip_cnt_next;
            clip_latch_reg <= clip_latch_next;
        end
    end

    // output register
    logic [LEVEL_W-1:0] out_left_level_reg;
    logic [LEVEL_W-1:0] out_right_level_reg;
    logic [LIT_W-1:0]   out_left_lit_reg;
    logic [LIT_W-1:0]   out_right_lit_reg;
    logic               out_clip_on_reg;
    logic               out_clip_seen_reg;

    always_ff @(posedge clk)
    begin
        if (clip_step)
        begin
            out_left_level_reg  <= left_level;
            out_right_level_reg <= right_level;
            out_left_lit_reg    <= left_lit;
            out_right_lit_reg   <= right_lit;
            out_clip_on_reg     <= (clip_cnt_next != '0);
            out_clip_seen_reg   <= clip_latch_next;
        end
    end

    assign m_tdata = {4'b0000, out_clip_seen_reg, out_clip_on_reg, out_right_lit_reg,
                      out_left_lit_reg, out_right_level_reg, out_left_level_reg};

    `SPM_ASSERT_NOW(a_cnt_needs_latch, clip_cnt_reg != '0, clip_latch_reg)
    `SPM_ASSERT_NEXT(a_clear_drops_clip, clip_step && (s1_cmd_reg == CMD_CLEAR),
                     !out_clip_on_reg && !out_clip_seen_reg)
    `SPM_ASSERT_NOW(a_zero_level_dark, out_valid_reg && (out_left_level_reg == '0),
                    out_left_lit_reg == '0)
    `SPM_ASSERT_NOW(a_out_from_pipe, $rose(out_valid_reg), $past(s1_valid_reg))

endmodule

### rtl/core/spm_channel.sv
// ----------------------------------------------------------------------------
// Peak meter channel
// Held level with multiplicative decay, and the lit segment count of it.
// ----------------------------------------------------------------------------
module spm_channel #(
    parameter int SEGMENTS = spm_pkg::SEGMENTS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        update,
    input  logic [spm_pkg::LEVEL_W-1:0] peak,
    input  logic [spm_pkg::LEVEL_W-1:0] decay,
    output logic [spm_pkg::LEVEL_W-1:0] level,
    output logic [spm_pkg::LIT_W-1:0]   lit
);
    import spm_pkg::*;

    localparam int CW = $clog2(SEGMENTS + 1);

    logic [LEVEL_W-1:0]   hold_reg;
    logic [LEVEL_W-1:0]   hold_next;
    logic [2*LEVEL_W-1:0] product;
    logic [LEVEL_W-1:0]   decayed;
    logic [SEGMENTS-1:0]  seg_on;
    logic [CW-1:0]        count;

    assign product = hold_reg * decay;
    assign decayed = product[2*LEVEL_W-1:LEVEL_W];

    always_comb
    begin
        hold_next = hold_reg;
        if (update)
        begin
            hold_next = (peak > decayed) ? peak : decayed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= '0;
        end
        else
        begin
            hold_reg <= hold_next;
        end
    end

    // compare against the build-time dB thresholds
    for (genvar g = 0; g < SEGMENTS; g++)
    begin : g_seg
        localparam logic [THR_W-1:0] THR = spm_threshold(SEGMENTS, g);
        assign seg_on[g] = ({1'b0, hold_reg} >= THR);
    end

    always_comb
    begin
        count = '0;
        for (int i = 0; i < SEGMENTS; i++)
        begin
            count = count + CW'(seg_on[i]);
        end
    end

    assign level = hold_reg;
    assign lit   = LIT_W'(count);

endmodule
